// ----- src/dqe_pkg.sv -----
// types and codes shared by the double ended queue modules
package dqe_pkg;

  localparam int OP_BITS     = 3;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_LIST       = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [VALUE_BITS-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  data;
    logic [COUNT_BITS-1:0]  count;
    logic                   last;
  } rsp_word_t;

  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_LIST       = 3'd4,
    K_NOP        = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ----- src/dqe_front.sv -----
// request intake: decodes each word into a command and queues it for the back end
module dqe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dqe_pkg::req_word_t  req,
  output dqe_pkg::cmd_chan_t  cmd_chan,
  input  logic                cmd_take
);

  dqe_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;
  dqe_pkg::cmd_t decoded;

  always_comb begin
    decoded.value = req.value;
    unique case (req.operation)
      dqe_pkg::OP_PUSH_FRONT: decoded.kind = dqe_pkg::K_PUSH_FRONT;
      dqe_pkg::OP_PUSH_BACK:  decoded.kind = dqe_pkg::K_PUSH_BACK;
      dqe_pkg::OP_POP_FRONT:  decoded.kind = dqe_pkg::K_POP_FRONT;
      dqe_pkg::OP_POP_BACK:   decoded.kind = dqe_pkg::K_POP_BACK;
      dqe_pkg::OP_LIST:       decoded.kind = dqe_pkg::K_LIST;
      default:                decoded.kind = dqe_pkg::K_NOP;
    endcase
  end

  assign req_stall      = (fill == 2'd2);
  assign push           = req_valid && !req_stall;
  assign pop            = cmd_chan.valid && cmd_take;
  assign cmd_chan.valid = (fill != 2'd0);
  assign cmd_chan.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/dqe_back.sv -----
// command execution: ring slots, front index, element count and the result register
module dqe_back #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dqe_pkg::cmd_chan_t cmd_chan,
  output logic               cmd_take,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dqe_pkg::rsp_word_t rsp
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int SB   = (WORD_BITS < dqe_pkg::VALUE_BITS) ? WORD_BITS : dqe_pkg::VALUE_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [SB-1:0]      mem [DEPTH];
  logic [SB-1:0]      rd_data;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      front, front_next;
  logic [CNTW-1:0]    cnt, cnt_next;
  logic [IW-1:0]      list_i, list_i_next;
  logic               pop_mode, pop_mode_next;
  logic               rsp_load;
  dqe_pkg::rsp_word_t rsp_next;
  logic               rsp_free;
  logic               full;
  logic               empty;
  logic               is_last;
  logic [IW-1:0]      back_off;
  logic [IW-1:0]      front_dec;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] f, input logic [IW-1:0] o);
    logic [IW:0] s;
    s = {1'b0, f} + {1'b0, o};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign full      = (cnt == CNTW'(DEPTH));
  assign empty     = (cnt == '0);
  assign back_off  = IW'(cnt - CNTW'(1));
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign is_last   = pop_mode || (list_i == back_off);

  always_comb begin
    state_next    = state;
    front_next    = front;
    cnt_next      = cnt;
    list_i_next   = list_i;
    pop_mode_next = pop_mode;
    cmd_take      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = front;
    wr_en         = 1'b0;
    wr_addr       = front;
    rsp_load      = 1'b0;
    rsp_next      = rsp;
    unique case (state)
      S_IDLE: begin
        if (cmd_chan.valid && rsp_free) begin
          cmd_take        = 1'b1;
          rsp_next.status = dqe_pkg::ST_OK;
          rsp_next.data   = '0;
          rsp_next.count  = dqe_pkg::COUNT_BITS'(cnt);
          rsp_next.last   = 1'b1;
          unique case (cmd_chan.cmd.kind)
            dqe_pkg::K_PUSH_FRONT, dqe_pkg::K_PUSH_BACK: begin
              rsp_load = 1'b1;
              if (full) begin
                rsp_next.status = dqe_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                if (cmd_chan.cmd.kind == dqe_pkg::K_PUSH_FRONT) begin
                  wr_addr    = front_dec;
                  front_next = front_dec;
                end else begin
                  wr_addr = wrap_add(front, IW'(cnt));
                end
                cnt_next       = cnt + CNTW'(1);
                rsp_next.count = dqe_pkg::COUNT_BITS'(cnt_next);
              end
            end
            dqe_pkg::K_POP_FRONT, dqe_pkg::K_POP_BACK: begin
              if (empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = dqe_pkg::ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                pop_mode_next = 1'b1;
                cnt_next      = cnt - CNTW'(1);
                state_next    = S_EMIT;
                if (cmd_chan.cmd.kind == dqe_pkg::K_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = wrap_add(front, IW'(1));
                end else begin
                  rd_addr = wrap_add(front, back_off);
                end
              end
            end
            dqe_pkg::K_LIST: begin
              if (empty) begin
                rsp_load        = 1'b1;
                rsp_next.status = dqe_pkg::ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = front;
                list_i_next   = '0;
                pop_mode_next = 1'b0;
                state_next    = S_EMIT;
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (rsp_free) begin
          rsp_load        = 1'b1;
          rsp_next.status = dqe_pkg::ST_OK;
          rsp_next.data   = dqe_pkg::VALUE_BITS'(rd_data);
          rsp_next.count  = dqe_pkg::COUNT_BITS'(cnt);
          rsp_next.last   = is_last;
          if (is_last) begin
            state_next = S_IDLE;
          end else begin
            list_i_next = list_i + IW'(1);
            rd_en       = 1'b1;
            rd_addr     = wrap_add(front, list_i_next);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= SB'(cmd_chan.cmd.value);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    list_i   <= list_i_next;
    pop_mode <= pop_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      cnt   <= cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/double_ended_queue.sv -----
// Bounded double ended queue of DEPTH words kept as a ring buffer. Each request word pushes
// at the front or back, pops from the front or back, or lists the contents front to back;
// every result word carries a status, the element count after the operation and a last flag.
// A two-entry command queue sits between intake and execution, so up to two requests are still
// taken while a result waits. In the back end a push, an unused code, or a pop or listing of
// an empty queue forms its result straight from the command; a pop registers the slot read
// before the result is formed, and a listing reads the elements held one after another
// through the single read port of the slot memory, one result word for each.
module double_ended_queue #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dqe_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dqe_pkg::rsp_word_t rsp
);

  dqe_pkg::cmd_chan_t cmd_chan;
  logic               cmd_take;

  dqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_chan  (cmd_chan),
    .cmd_take  (cmd_take)
  );

  dqe_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_chan  (cmd_chan),
    .cmd_take  (cmd_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- bench/double_ended_queue_check.sv -----
// checker for the double ended queue: tracks the ring, predicts result words, compares
module double_ended_queue_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  dqe_pkg::req_word_t          req,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  dqe_pkg::rsp_word_t          rsp,
  output int                          fail_count,
  output int                          pending,
  output int                          held_words,
  output int                          words_checked,
  output int                          full_refusals,
  output int                          empty_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 64;
  localparam int DUE_SLOTS = 1024;

  logic [dqe_pkg::VALUE_BITS-1:0] ring [DEPTH];
  logic [5:0]                     head;
  logic [dqe_pkg::COUNT_BITS-1:0] fill;
  dqe_pkg::rsp_word_t             due_words [DUE_SLOTS];
  int                             due_wr;
  int                             due_rd;

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result word %0d: %s is %0h, expected %0h",
             words_checked, field, got, want);
    fail_count++;
  endtask

  function automatic void put_word(logic [dqe_pkg::STATUS_BITS-1:0] st,
                                   logic [dqe_pkg::VALUE_BITS-1:0] d, logic lst);
    dqe_pkg::rsp_word_t w;
    w.status = st;
    w.data   = d;
    w.count  = fill;
    w.last   = lst;
    due_words[due_wr % DUE_SLOTS] = w;
    due_wr++;
  endfunction

  function automatic void apply_request(dqe_pkg::req_word_t w);
    logic [5:0] slot;
    case (w.operation)
      dqe_pkg::OP_PUSH_FRONT, dqe_pkg::OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          put_word(dqe_pkg::ST_FULL, '0, 1'b1);
          full_refusals++;
        end else begin
          if (w.operation == dqe_pkg::OP_PUSH_FRONT) begin
            head = head - 1'b1;
            slot = head;
          end else begin
            slot = head + fill[5:0];
          end
          ring[slot] = w.value;
          fill = fill + 1'b1;
          put_word(dqe_pkg::ST_OK, '0, 1'b1);
        end
      end
      dqe_pkg::OP_POP_FRONT, dqe_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          put_word(dqe_pkg::ST_EMPTY, '0, 1'b1);
          empty_reports++;
        end else begin
          if (w.operation == dqe_pkg::OP_POP_FRONT) begin
            slot = head;
            head = head + 1'b1;
          end else begin
            slot = head + fill[5:0] - 1'b1;
          end
          fill = fill - 1'b1;
          put_word(dqe_pkg::ST_OK, ring[slot], 1'b1);
        end
      end
      dqe_pkg::OP_LIST: begin
        if (fill == 0) begin
          put_word(dqe_pkg::ST_EMPTY, '0, 1'b1);
          empty_reports++;
        end else begin
          for (int i = 0; i < fill; i++) begin
            slot = head + i[5:0];
            put_word(dqe_pkg::ST_OK, ring[slot], i == fill - 1);
          end
        end
      end
      default: put_word(dqe_pkg::ST_OK, '0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    dqe_pkg::rsp_word_t want;
    if (rst) begin
      head   = '0;
      fill   = '0;
      due_wr = 0;
      due_rd = 0;
    end else begin
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid && !rsp_stall) begin
        if (due_wr == due_rd) begin
          flag_mismatch("unexpected word, data", rsp.data, '0);
        end else begin
          want = due_words[due_rd % DUE_SLOTS];
          due_rd++;
          if (rsp.status !== want.status) begin
            flag_mismatch("status", 32'(rsp.status), 32'(want.status));
          end
          if (rsp.data !== want.data) flag_mismatch("data", rsp.data, want.data);
          if (rsp.count !== want.count) begin
            flag_mismatch("count", 32'(rsp.count), 32'(want.count));
          end
          if (rsp.last !== want.last) begin
            flag_mismatch("last", 32'(rsp.last), 32'(want.last));
          end
        end
        words_checked++;
      end
    end
    pending    = due_wr - due_rd;
    held_words = 32'(fill);
  end

endmodule

// ----- bench/double_ended_queue_test.sv -----
// testbench top for the double ended queue: reset, request stimulus, receiver stalls and verdict
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 64;
  localparam int RUN_ITEMS     = 110;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [dqe_pkg::OP_BITS-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [dqe_pkg::OP_BITS-1:0] OP_UNUSED_LAST  = 3'd7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  dqe_pkg::req_word_t req       = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  dqe_pkg::rsp_word_t rsp;

  int fail_count, pending, held_words, words_checked, full_refusals, empty_reports;
  int sent = 0;
  int directed_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  double_ended_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  double_ended_queue_check u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .pending      (pending),
    .held_words   (held_words),
    .words_checked(words_checked),
    .full_refusals(full_refusals),
    .empty_reports(empty_reports)
  );

  // receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out with %0d result words still expected", pending);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic set_idling(int mode);
    gap_pct   = (mode == 1) ? 54 : (mode == 3) ? 11 : 0;
    stall_pct = (mode == 2) ? 54 : (mode == 3) ? 11 : 0;
  endtask

  function automatic logic [dqe_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(logic [dqe_pkg::OP_BITS-1:0] op,
                           logic [dqe_pkg::VALUE_BITS-1:0] val);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    req.operation <= op;
    req.value     <= val;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic push_any(logic [dqe_pkg::VALUE_BITS-1:0] val);
    send_word($urandom_range(1) ? dqe_pkg::OP_PUSH_BACK : dqe_pkg::OP_PUSH_FRONT, val);
  endtask

  task automatic pop_any();
    send_word($urandom_range(1) ? dqe_pkg::OP_POP_BACK : dqe_pkg::OP_POP_FRONT, $urandom());
  endtask

  initial begin
    int n;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // empty queue, unused codes, front push wrapping below slot zero
    send_word(dqe_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    send_word(dqe_pkg::OP_POP_BACK, '0);
    send_word(dqe_pkg::OP_LIST, $urandom());
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) send_word(c[2:0], '1);
    send_word(dqe_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(dqe_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_word(dqe_pkg::OP_PUSH_FRONT, 32'h0000_0001);
    send_word(dqe_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_word(dqe_pkg::OP_LIST, '0);
    send_word(dqe_pkg::OP_POP_BACK, '1);
    send_word(dqe_pkg::OP_POP_FRONT, '0);
    send_word(dqe_pkg::OP_PUSH_BACK, 32'h5555_5555);
    send_word(dqe_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(dqe_pkg::OP_LIST, '1);
    send_word(dqe_pkg::OP_POP_FRONT, '0);
    send_word(dqe_pkg::OP_POP_FRONT, '0);
    send_word(dqe_pkg::OP_POP_BACK, '0);
    send_word(dqe_pkg::OP_LIST, '0);
    directed_count = sent;

    // fill to capacity behind a long receiver hold-off, overflow, list everything
    set_idling(0);
    hold_asked++;
    @(negedge clk);
    n = DEPTH + 2 - held_words;
    for (int k = 0; k < n; k++) begin
      set_idling((k / 17) % 4);
      push_any(pick_value());
    end
    send_word(dqe_pkg::OP_LIST, $urandom());
    send_word(dqe_pkg::OP_POP_FRONT, $urandom());
    send_word(dqe_pkg::OP_PUSH_FRONT, pick_value());
    send_word(dqe_pkg::OP_PUSH_BACK, pick_value());
    send_word(dqe_pkg::OP_POP_BACK, $urandom());

    while (sent < RUN_ITEMS) begin
      set_idling((sent / 5) % 4);
      case ($urandom_range(9))
        0, 1, 2, 3: repeat ($urandom_range(6, 1)) push_any(pick_value());
        4, 5:       repeat ($urandom_range(6, 1)) pop_any();
        6, 7:       send_word(dqe_pkg::OP_LIST, $urandom());
        8: begin
          n = $urandom_range(4, 1);
          repeat (n) push_any(pick_value());
          repeat (n) pop_any();
        end
        default:    send_word(dqe_pkg::OP_BITS'($urandom_range(7)), $urandom());
      endcase
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d requests sent (%0d directed), %0d result words checked",
             sent, directed_count, words_checked);
    $display("%0d pushes refused when full, %0d empty reports, %0d long receiver hold-offs",
             full_refusals, empty_reports, hold_done);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dqe_pkg.sv
src/dqe_front.sv
src/dqe_back.sv
src/double_ended_queue.sv
bench/double_ended_queue_check.sv
bench/double_ended_queue_test.sv
